[rtl/srp_pkg.sv]
// Shared constants, types and helpers for the shelf rectangle packer.
`timescale 1ns / 1ps
`default_nettype none
package srp_pkg;
	localparam int MAX_PAGES_DEF   = 8;
	localparam int MAX_SHELVES_DEF = 64;

	localparam logic [2:0] REG_PAGE_W = 3'd0;
	localparam logic [2:0] REG_PAGE_H = 3'd1;
	localparam logic [2:0] REG_LIMIT  = 3'd2;
	localparam logic [2:0] REG_PAD    = 3'd3;
	localparam logic [2:0] REG_INV_W  = 3'd4;
	localparam logic [2:0] REG_INV_H  = 3'd5;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef struct packed {
		logic [12:0] page_width;
		logic [12:0] page_height;
		logic [3:0]  page_limit;
		logic [7:0]  pad;
		logic [24:0] inv_width;
		logic [24:0] inv_height;
	} cfg_t;

	// one shelf entry: top row, height, filled width
	typedef struct packed {
		logic [12:0] top;
		logic [12:0] tall;
		logic [12:0] fill;
	} shelf_t;

	// saturate a rounded 1.16 coordinate
	function automatic logic [16:0] uv_sat(input logic [38:0] prod);
		logic [38:0] v;
		v = (prod + 39'd128) >> 8;
		uv_sat = (v > 39'd65536) ? 17'd65536 : v[16:0];
	endfunction
endpackage
`default_nettype wire

[rtl/srp_cfg_regs.sv]
// APB register block for the packer configuration.
`timescale 1ns / 1ps
`default_nettype none
module srp_cfg_regs
	import srp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);
	cfg_t cfg_q;
	logic [2:0] idx;
	assign idx = paddr[4:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.page_width  <= 13'd1024;
			cfg_q.page_height <= 13'd1024;
			cfg_q.page_limit  <= 4'd8;
			cfg_q.pad         <= 8'd0;
			cfg_q.inv_width   <= 25'd16384;
			cfg_q.inv_height  <= 25'd16384;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_PAGE_W: cfg_q.page_width  <= pwdata[12:0];
				REG_PAGE_H: cfg_q.page_height <= pwdata[12:0];
				REG_LIMIT:  cfg_q.page_limit  <= pwdata[3:0];
				REG_PAD:    cfg_q.pad         <= pwdata[7:0];
				REG_INV_W:  cfg_q.inv_width   <= pwdata[24:0];
				REG_INV_H:  cfg_q.inv_height  <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PAGE_W: prdata = {19'd0, cfg_q.page_width};
			REG_PAGE_H: prdata = {19'd0, cfg_q.page_height};
			REG_LIMIT:  prdata = {28'd0, cfg_q.page_limit};
			REG_PAD:    prdata = {24'd0, cfg_q.pad};
			REG_INV_W:  prdata = {7'd0, cfg_q.inv_width};
			REG_INV_H:  prdata = {7'd0, cfg_q.inv_height};
			default:    prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

[rtl/srp_shelf_ram.sv]
// Shelf table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module srp_shelf_ram
	import srp_pkg::*;
#(
	parameter int AW = 9
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire shelf_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output shelf_t             rdata
);
	shelf_t mem [2**AW];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/shelf_rect_packer_unit.sv]
// Top level of the shelf rectangle packer.
// Flow: a remove goes straight to the done step. An insert walks the open pages in order,
// reading and comparing each shelf, tries a new shelf on that page, then tries opening a
// new page, and once placed passes the coordinate stages S_UV1 and S_UV2 before done.
// Only one word is in flight at a time.
// Reset (arst_n low) clears state, page counters, totals and out_valid; shelf RAM is not cleared.
// A finished result sits in the output register while the next word may be taken.
`timescale 1ns / 1ps
`default_nettype none
module shelf_rect_packer_unit
	import srp_pkg::*;
#(
	parameter int MAX_PAGES   = MAX_PAGES_DEF,
	parameter int MAX_SHELVES = MAX_SHELVES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [12:0] rect_width,
	input  wire logic [12:0] rect_height,
	input  wire logic        entry_valid,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             ok,
	output logic [2:0]       page,
	output logic [11:0]      pos_x,
	output logic [11:0]      pos_y,
	output logic [16:0]      tex_u0,
	output logic [16:0]      tex_v0,
	output logic [16:0]      tex_u1,
	output logic [16:0]      tex_v1,
	output logic [19:0]      entry_total,
	output logic [47:0]      pixels_used,
	output logic [3:0]       pages_open
);
	localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int SW  = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
	localparam int CW  = $clog2(MAX_SHELVES + 1);
	localparam int OW  = $clog2(MAX_PAGES + 1);
	localparam int AW  = PW + SW;

	cfg_t cfg;
	srp_cfg_regs u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	typedef enum logic [3:0] {
		S_IDLE, S_PAGE, S_RD, S_CMP, S_NEW, S_OPEN, S_UV1, S_UV2, S_DONE
	} state_t;
	state_t state_q;

	logic [CW-1:0] shelf_count_q [MAX_PAGES];
	logic [13:0]   next_row_q    [MAX_PAGES];
	logic [OW-1:0] open_q;
	logic [19:0]   live_q;
	logic [47:0]   area_q;

	logic          cmd_q, ev_q, tried_new_q, hit_q;
	logic [12:0]   w_q, h_q;
	logic [13:0]   pw_q, ph_q;
	logic [PW-1:0] pg_q;
	logic [CW-1:0] sh_q;
	logic [13:0]   px_q, py_q;
	logic [38:0]   m0_q, m1_q, m2_q, m3_q;
	logic [13:0]   x_q, y_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	shelf_t        wdata, rdata;
	srp_shelf_ram #(.AW(AW)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	assign raddr = {pg_q, sh_q[SW-1:0]};

	logic [CW-1:0] cnt_cur;
	logic [13:0]   row_cur;
	logic          fit_old, fit_new;
	logic [3:0]    open_ext;
	logic [14:0]   fill_sum;
	logic [14:0]   row_sum;
	logic          done_fire;
	logic [19:0]   live_inc, live_dec;
	logic [47:0]   area_w;
	assign cnt_cur  = shelf_count_q[pg_q];
	assign row_cur  = next_row_q[pg_q];
	assign fill_sum = {2'd0, rdata.fill} + {1'b0, pw_q};
	assign fit_old  = ({1'b0, ph_q} <= {2'd0, rdata.tall}) &&
		(fill_sum <= {2'd0, cfg.page_width});
	assign row_sum  = {1'b0, row_cur} + {1'b0, ph_q};
	assign fit_new  = (cnt_cur < CW'(MAX_SHELVES)) && (row_sum <= {2'd0, cfg.page_height});
	assign open_ext = 4'(open_q);
	assign done_fire = (state_q == S_DONE) && !(out_valid && out_stall);
	assign live_inc = (live_q != 20'hFFFFF) ? live_q + 20'd1 : live_q;
	assign live_dec = (live_q != '0) ? live_q - 20'd1 : live_q;
	assign area_w   = {22'd0, {13'd0, w_q} * {13'd0, h_q}};

	always_comb begin
		we = 1'b0;
		waddr = raddr;
		wdata = rdata;
		if (state_q == S_CMP && fit_old) begin
			we = 1'b1;
			wdata.fill = fill_sum[12:0];
		end else if (state_q == S_NEW && fit_new) begin
			we = 1'b1;
			waddr = {pg_q, cnt_cur[SW-1:0]};
			wdata.top = row_cur[12:0];
			wdata.tall = ph_q[12:0];
			wdata.fill = pw_q[12:0];
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			open_q <= '0;
			live_q <= '0;
			area_q <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < MAX_PAGES; i++) begin
				shelf_count_q[i] <= '0;
				next_row_q[i] <= '0;
			end
		end else begin
			if (done_fire) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && !in_stall) begin
					cmd_q <= command; ev_q <= entry_valid;
					w_q <= rect_width; h_q <= rect_height;
					pw_q <= 14'(rect_width) + {5'd0, cfg.pad, 1'b0};
					ph_q <= 14'(rect_height) + {5'd0, cfg.pad, 1'b0};
					pg_q <= '0; sh_q <= '0; tried_new_q <= 1'b0; hit_q <= 1'b0;
					state_q <= (command == CMD_REMOVE) ? S_DONE : S_PAGE;
				end
				S_PAGE: begin
					// walk pages in order, then try opening one
					if (!tried_new_q && OW'(pg_q) < open_q) begin
						sh_q <= '0;
						state_q <= (cnt_cur == '0) ? S_NEW : S_RD;
					end else state_q <= S_OPEN;
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (fit_old) begin
						hit_q <= 1'b1; px_q <= {1'b0, rdata.fill}; py_q <= {1'b0, rdata.top};
						state_q <= S_UV1;
					end else if (sh_q + 1'b1 < cnt_cur) begin
						sh_q <= sh_q + 1'b1; state_q <= S_RD;
					end else state_q <= S_NEW;
				end
				S_NEW: begin
					if (fit_new) begin
						hit_q <= 1'b1; px_q <= '0; py_q <= row_cur;
						next_row_q[pg_q] <= row_sum[13:0];
						shelf_count_q[pg_q] <= cnt_cur + 1'b1;
						state_q <= S_UV1;
					end else if (tried_new_q) state_q <= S_DONE;
					else if (OW'(pg_q) + 1'b1 < open_q) begin
						pg_q <= pg_q + 1'b1; state_q <= S_PAGE;
					end else state_q <= S_OPEN;
				end
				S_OPEN: begin
					if (!tried_new_q && open_ext < cfg.page_limit &&
						open_q < OW'(MAX_PAGES)) begin
						pg_q <= PW'(open_q);
						shelf_count_q[PW'(open_q)] <= '0;
						next_row_q[PW'(open_q)] <= '0;
						open_q <= open_q + 1'b1;
						tried_new_q <= 1'b1;
						state_q <= S_NEW;
					end else state_q <= S_DONE;
				end
				S_UV1: begin
					x_q <= px_q + 14'(cfg.pad);
					y_q <= py_q + 14'(cfg.pad);
					state_q <= S_UV2;
				end
				S_UV2: begin
					m0_q <= 39'(x_q) * 39'(cfg.inv_width);
					m1_q <= 39'(y_q) * 39'(cfg.inv_height);
					m2_q <= 39'(x_q + 14'(w_q)) * 39'(cfg.inv_width);
					m3_q <= 39'(y_q + 14'(h_q)) * 39'(cfg.inv_height);
					state_q <= S_DONE;
				end
				S_DONE: if (done_fire) begin
					pages_open <= 4'(open_q);
					if (cmd_q == CMD_INSERT && hit_q) begin
						ok <= 1'b1; page <= 3'(pg_q);
						pos_x <= x_q[11:0]; pos_y <= y_q[11:0];
						tex_u0 <= uv_sat(m0_q); tex_v0 <= uv_sat(m1_q);
						tex_u1 <= uv_sat(m2_q); tex_v1 <= uv_sat(m3_q);
						entry_total <= live_inc;
						pixels_used <= area_q + area_w;
						live_q <= live_inc;
						area_q <= area_q + area_w;
					end else begin
						ok <= (cmd_q == CMD_REMOVE) && ev_q;
						page <= '0; pos_x <= '0; pos_y <= '0;
						tex_u0 <= '0; tex_v0 <= '0; tex_u1 <= '0; tex_v1 <= '0;
						if (cmd_q == CMD_REMOVE && ev_q) begin
							entry_total <= live_dec;
							pixels_used <= area_q - area_w;
							live_q <= live_dec;
							area_q <= area_q - area_w;
						end else begin
							entry_total <= live_q;
							pixels_used <= area_q;
						end
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= OW'(MAX_PAGES)) else $error("open page count beyond limit");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("word taken while busy");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_DONE) else $error("result without done");
endmodule
`default_nettype wire
